/* design/swrm_pkg.sv */
// Shared types, constants and microcode for the sliding-window rate meter.
package swrm_pkg;

  localparam int MAX_BUCKETS = 512;
  localparam int SLOT_W      = $clog2(MAX_BUCKETS);
  localparam int RING_W      = SLOT_W + 1;

  localparam int CMD_W    = 2;
  localparam int TIME_W   = 48;
  localparam int BYTE_W   = 32;
  localparam int EVT_W    = 16;
  localparam int TOTB_W   = 48;
  localparam int TOTE_W   = 40;
  localparam int BKTB_W   = 40;
  localparam int BKTE_W   = 32;
  localparam int SHIFT_W  = 5;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [RING_W-1:0]  RING_MIN      = RING_W'(2);
  localparam logic [RING_W-1:0]  RING_MAX      = RING_W'(MAX_BUCKETS);
  localparam logic [RING_W-1:0]  ACTIVE_RESET  = RING_W'(20);
  localparam logic [SHIFT_W-1:0] SHIFT_RESET   = SHIFT_W'(10);

  localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADV = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLR = 2'd2;

  localparam logic REG_ACTIVE = 1'b0;
  localparam logic REG_SHIFT  = 1'b1;

  typedef struct packed {
    logic [BKTB_W-1:0] bytes;
    logic [BKTE_W-1:0] events;
  } bucket_t;

  // datapath operations
  localparam logic [3:0] OP_NOP   = 4'd0;
  localparam logic [3:0] OP_LATCH = 4'd1;
  localparam logic [3:0] OP_TGT   = 4'd2;
  localparam logic [3:0] OP_DIFF  = 4'd3;
  localparam logic [3:0] OP_WIPE  = 4'd4;
  localparam logic [3:0] OP_ROLL  = 4'd5;
  localparam logic [3:0] OP_CTR0  = 4'd6;
  localparam logic [3:0] OP_ARD   = 4'd7;
  localparam logic [3:0] OP_AWR   = 4'd8;
  localparam logic [3:0] OP_SCAN  = 4'd9;
  localparam logic [3:0] OP_OUT   = 4'd10;

  // jump conditions
  localparam logic [3:0] COND_NEVER     = 4'd0;
  localparam logic [3:0] COND_ALWAYS    = 4'd1;
  localparam logic [3:0] COND_NO_IN     = 4'd2;
  localparam logic [3:0] COND_NO_WIPE   = 4'd3;
  localparam logic [3:0] COND_NO_ROLL   = 4'd4;
  localparam logic [3:0] COND_NO_ADD    = 4'd5;
  localparam logic [3:0] COND_NOT_LAST  = 4'd6;
  localparam logic [3:0] COND_MORE_STEP = 4'd7;
  localparam logic [3:0] COND_OUT_FREE  = 4'd8;

  localparam int UPC_W = 4;

  // program steps
  localparam logic [UPC_W-1:0] STEP_WAIT    = 4'd0;
  localparam logic [UPC_W-1:0] STEP_TGT     = 4'd1;
  localparam logic [UPC_W-1:0] STEP_DIFF    = 4'd2;
  localparam logic [UPC_W-1:0] STEP_WIPE_BR = 4'd3;
  localparam logic [UPC_W-1:0] STEP_WIPE    = 4'd4;
  localparam logic [UPC_W-1:0] STEP_ROLL_BR = 4'd5;
  localparam logic [UPC_W-1:0] STEP_ROLL    = 4'd6;
  localparam logic [UPC_W-1:0] STEP_RDRAIN  = 4'd7;
  localparam logic [UPC_W-1:0] STEP_ADD_BR  = 4'd8;
  localparam logic [UPC_W-1:0] STEP_ARD     = 4'd9;
  localparam logic [UPC_W-1:0] STEP_AWR     = 4'd10;
  localparam logic [UPC_W-1:0] STEP_SCAN    = 4'd11;
  localparam logic [UPC_W-1:0] STEP_SDRAIN  = 4'd12;
  localparam logic [UPC_W-1:0] STEP_EMIT    = 4'd13;
  localparam logic [UPC_W-1:0] STEP_HOLD    = 4'd14;

  typedef struct packed {
    logic [3:0]       op;
    logic [3:0]       cond;
    logic [UPC_W-1:0] tgt;
  } ctl_word_t;

  typedef struct packed {
    logic in_valid;
    logic wipe;
    logic roll;
    logic add;
    logic ctr_last;
    logic step_last;
    logic out_free;
  } cond_flags_t;

  function automatic ctl_word_t ucode_rom(input logic [UPC_W-1:0] upc);
    ctl_word_t w;
    case (upc)
      STEP_WAIT:    w = '{OP_LATCH, COND_NO_IN,     STEP_WAIT};
      STEP_TGT:     w = '{OP_TGT,   COND_NEVER,     STEP_WAIT};
      STEP_DIFF:    w = '{OP_DIFF,  COND_NEVER,     STEP_WAIT};
      STEP_WIPE_BR: w = '{OP_NOP,   COND_NO_WIPE,   STEP_ROLL_BR};
      STEP_WIPE:    w = '{OP_WIPE,  COND_NOT_LAST,  STEP_WIPE};
      STEP_ROLL_BR: w = '{OP_NOP,   COND_NO_ROLL,   STEP_ADD_BR};
      STEP_ROLL:    w = '{OP_ROLL,  COND_MORE_STEP, STEP_ROLL};
      STEP_RDRAIN:  w = '{OP_NOP,   COND_NEVER,     STEP_WAIT};
      STEP_ADD_BR:  w = '{OP_CTR0,  COND_NO_ADD,    STEP_SCAN};
      STEP_ARD:     w = '{OP_ARD,   COND_NEVER,     STEP_WAIT};
      STEP_AWR:     w = '{OP_AWR,   COND_NEVER,     STEP_WAIT};
      STEP_SCAN:    w = '{OP_SCAN,  COND_NOT_LAST,  STEP_SCAN};
      STEP_SDRAIN:  w = '{OP_NOP,   COND_NEVER,     STEP_WAIT};
      STEP_EMIT:    w = '{OP_OUT,   COND_OUT_FREE,  STEP_WAIT};
      STEP_HOLD:    w = '{OP_NOP,   COND_ALWAYS,    STEP_EMIT};
      default:      w = '{OP_NOP,   COND_ALWAYS,    STEP_WAIT};
    endcase
    return w;
  endfunction

  function automatic logic [RING_W-1:0] ring_len(input logic [RING_W-1:0] act);
    logic [RING_W-1:0] n;
    n = act;
    if (n < RING_MIN) n = RING_MIN;
    if (n > RING_MAX) n = RING_MAX;
    return n;
  endfunction

endpackage

/* design/swrm_if.sv */
// Beat channels of the rate meter: command input and result output.
interface swrm_in_if import swrm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [TIME_W-1:0] time_ticks;
  logic [BYTE_W-1:0] byte_count;
  logic [EVT_W-1:0]  event_count;

  modport source (output valid, cmd, time_ticks, byte_count, event_count, input ready);
  modport sink   (input valid, cmd, time_ticks, byte_count, event_count, output ready);
endinterface

interface swrm_out_if import swrm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TOTB_W-1:0] total_bytes;
  logic [TOTE_W-1:0] total_events;
  logic [BKTB_W-1:0] peak_bucket_bytes;
  logic              primed;

  modport source (output valid, total_bytes, total_events, peak_bucket_bytes, primed,
                  input ready);
  modport sink   (input valid, total_bytes, total_events, peak_bucket_bytes, primed,
                  output ready);
endinterface

/* design/swrm_seq.sv */
// Microcode sequencer: step counter, control store and conditional jumps.
module swrm_seq import swrm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cond_flags_t flags,
  output ctl_word_t   ctl
);

  logic [UPC_W-1:0] upc_r, upc_nxt;
  logic             take;

  always_comb begin
    ctl = ucode_rom(upc_r);
    case (ctl.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_NO_IN:     take = !flags.in_valid;
      COND_NO_WIPE:   take = !flags.wipe;
      COND_NO_ROLL:   take = !flags.roll;
      COND_NO_ADD:    take = !flags.add;
      COND_NOT_LAST:  take = !flags.ctr_last;
      COND_MORE_STEP: take = !flags.step_last;
      COND_OUT_FREE:  take = flags.out_free;
      default:        take = 1'b0;
    endcase
    upc_nxt = take ? ctl.tgt : upc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= STEP_WAIT;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

/* design/sliding_window_rate_meter.sv */
// Bucketed sliding-window rate meter: top level with datapath and bucket memory.
//
// Commands arrive as beats on in_ch (add sample, advance time, clear); each
// command yields exactly one result beat on out_ch with the byte and event
// totals over the live buckets, the largest bucket byte count and the primed
// flag. Registers sit on the APB-style cfg_ port: active_buckets at 0x0 and
// bucket_shift at 0x4; a write to either clears the ring and totals.
// One command is worked at a time by a microcoded sequencer over a bucket
// RAM with one write and one read port. With n the clamped ring length, a
// command rolls out the buckets its time step passed over (0..n-1), or
// clears the whole ring (clear command, a gap of a full ring or more, or the
// first command after reset or a register write). The peak scan over n
// buckets reads one bucket a cycle, as does the roll; the clearing pass
// writes one bucket a cycle. A new command is accepted only after its
// predecessor's result is registered. The result register holds while
// out_ch.ready is low; the next command is still accepted and worked, and
// waits only to hand over its result. Reset (rst_n low, synchronous) restores
// the register defaults and empties the totals; the bucket RAM is cleared by
// the next command.
module sliding_window_rate_meter import swrm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  swrm_in_if.sink            in_ch,
  swrm_out_if.source         out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [CFG_AW-1:0]  cfg_paddr,
  input  logic [CFG_DW-1:0]  cfg_pwdata,
  output logic [CFG_DW-1:0]  cfg_prdata,
  output logic               cfg_pready
);

  ctl_word_t   ctl;
  cond_flags_t flags;

  // configuration
  logic [RING_W-1:0]  act_r, act_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic               cfg_wr;
  logic [RING_W-1:0]  n_ring;
  logic [SLOT_W-1:0]  ring_m1;

  // latched command
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic [EVT_W-1:0]  evt_r, evt_nxt;

  // work registers
  logic [TIME_W-1:0] target_r, target_nxt;
  logic [SLOT_W-1:0] steps_r, steps_nxt;
  logic [SLOT_W-1:0] ctr_r, ctr_nxt;
  logic [BKTB_W-1:0] peak_r, peak_nxt;
  logic              wipe_r, wipe_nxt;
  logic              roll_r, roll_nxt;
  logic              sub_v_r, sub_v_nxt;
  logic              cmp_v_r, cmp_v_nxt;
  logic              clr_pend_r, clr_pend_nxt;

  // meter state
  logic [TOTB_W-1:0] sum_b_r, sum_b_nxt;
  logic [TOTE_W-1:0] sum_e_r, sum_e_nxt;
  logic [TIME_W-1:0] newest_r, newest_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              idx_valid_r, idx_valid_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  logic [TOTB_W-1:0] out_tb_r, out_tb_nxt;
  logic [TOTE_W-1:0] out_te_r, out_te_nxt;
  logic [BKTB_W-1:0] out_pk_r, out_pk_nxt;
  logic              out_pr_r, out_pr_nxt;
  logic              out_free;

  // bucket RAM
  bucket_t           mem [MAX_BUCKETS];
  bucket_t           rd_data_r;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr, mem_raddr;
  bucket_t           mem_wdata;

  logic [TIME_W-1:0] diff;
  logic              gt, big, is_adv;
  logic [SLOT_W-1:0] slot_adv;
  logic [BKTB_W:0]   bkt_b_sum;
  logic [BKTE_W:0]   bkt_e_sum;
  logic [TOTB_W:0]   tot_b_sum;
  logic [TOTE_W:0]   tot_e_sum;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_SHIFT) ? CFG_DW'(shift_r) : CFG_DW'(act_r);

  assign n_ring   = ring_len(act_r);
  assign ring_m1  = SLOT_W'(n_ring - 1'b1);
  assign slot_adv = (slot_r == ring_m1) ? '0 : slot_r + 1'b1;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready = (ctl.op == OP_LATCH);

  assign out_ch.valid             = out_valid_r;
  assign out_ch.total_bytes       = out_tb_r;
  assign out_ch.total_events      = out_te_r;
  assign out_ch.peak_bucket_bytes = out_pk_r;
  assign out_ch.primed            = out_pr_r;

  always_comb begin
    flags.in_valid  = in_ch.valid;
    flags.wipe      = wipe_r;
    flags.roll      = roll_r;
    flags.add       = (cmd_r == CMD_ADD);
    flags.ctr_last  = (ctr_r == ring_m1);
    flags.step_last = (steps_r == SLOT_W'(1));
    flags.out_free  = out_free;
  end

  swrm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .ctl   (ctl)
  );

  assign diff   = target_r - newest_r;
  assign gt     = target_r > newest_r;
  assign big    = diff >= TIME_W'(n_ring);
  assign is_adv = (cmd_r == CMD_ADD) || (cmd_r == CMD_ADV);

  // saturating adds of the sample into the newest bucket and the totals
  always_comb begin
    bkt_b_sum = {1'b0, rd_data_r.bytes} + (BKTB_W + 1)'(byte_r);
    bkt_e_sum = {1'b0, rd_data_r.events} + (BKTE_W + 1)'(evt_r);
    tot_b_sum = {1'b0, sum_b_r} + (TOTB_W + 1)'(byte_r);
    tot_e_sum = {1'b0, sum_e_r} + (TOTE_W + 1)'(evt_r);
  end

  // RAM port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_r;
    mem_raddr = slot_r;
    mem_wdata = '0;
    case (ctl.op)
      OP_WIPE: begin
        mem_we    = 1'b1;
        mem_waddr = ctr_r;
      end
      OP_ROLL: begin
        // read the old contents and zero the bucket in the same cycle
        mem_we    = 1'b1;
        mem_waddr = slot_adv;
        mem_raddr = slot_adv;
      end
      OP_AWR: begin
        mem_we           = 1'b1;
        mem_wdata.bytes  = bkt_b_sum[BKTB_W] ? '1 : bkt_b_sum[BKTB_W-1:0];
        mem_wdata.events = bkt_e_sum[BKTE_W] ? '1 : bkt_e_sum[BKTE_W-1:0];
      end
      OP_SCAN: mem_raddr = ctr_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  // datapath next state
  always_comb begin
    act_nxt       = act_r;
    shift_nxt     = shift_r;
    cmd_nxt       = cmd_r;
    time_nxt      = time_r;
    byte_nxt      = byte_r;
    evt_nxt       = evt_r;
    target_nxt    = target_r;
    steps_nxt     = steps_r;
    ctr_nxt       = ctr_r;
    peak_nxt      = peak_r;
    wipe_nxt      = wipe_r;
    roll_nxt      = roll_r;
    clr_pend_nxt  = clr_pend_r;
    sum_b_nxt     = sum_b_r;
    sum_e_nxt     = sum_e_r;
    newest_nxt    = newest_r;
    slot_nxt      = slot_r;
    idx_valid_nxt = idx_valid_r;
    out_tb_nxt    = out_tb_r;
    out_te_nxt    = out_te_r;
    out_pk_nxt    = out_pk_r;
    out_pr_nxt    = out_pr_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    sub_v_nxt     = (ctl.op == OP_ROLL);
    cmp_v_nxt     = (ctl.op == OP_SCAN);

    case (ctl.op)
      OP_LATCH: begin
        if (in_ch.valid) begin
          cmd_nxt  = in_ch.cmd;
          time_nxt = in_ch.time_ticks;
          byte_nxt = in_ch.byte_count;
          evt_nxt  = in_ch.event_count;
        end
      end
      OP_TGT: target_nxt = time_r >> shift_r;
      OP_DIFF: begin
        ctr_nxt   = '0;
        steps_nxt = diff[SLOT_W-1:0];
        wipe_nxt  = clr_pend_r || (cmd_r == CMD_CLR) || (is_adv && idx_valid_r && gt && big);
        roll_nxt  = is_adv && idx_valid_r && gt && !big;
        if (cmd_r == CMD_CLR) begin
          sum_b_nxt     = '0;
          sum_e_nxt     = '0;
          newest_nxt    = '0;
          slot_nxt      = '0;
          idx_valid_nxt = 1'b0;
        end else if (is_adv) begin
          // with the ring empty, any slot serves as the newest one
          if (!idx_valid_r) begin
            idx_valid_nxt = 1'b1;
            newest_nxt    = target_r;
          end else if (gt) begin
            newest_nxt = target_r;
            if (big) begin
              sum_b_nxt = '0;
              sum_e_nxt = '0;
            end
          end
        end
      end
      OP_WIPE: begin
        ctr_nxt      = ctr_r + 1'b1;
        clr_pend_nxt = 1'b0;
      end
      OP_ROLL: begin
        slot_nxt  = slot_adv;
        steps_nxt = steps_r - 1'b1;
      end
      OP_CTR0: begin
        ctr_nxt  = '0;
        peak_nxt = '0;
      end
      OP_AWR: begin
        sum_b_nxt = tot_b_sum[TOTB_W] ? '1 : tot_b_sum[TOTB_W-1:0];
        sum_e_nxt = tot_e_sum[TOTE_W] ? '1 : tot_e_sum[TOTE_W-1:0];
      end
      OP_SCAN: ctr_nxt = ctr_r + 1'b1;
      OP_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_tb_nxt    = sum_b_r;
          out_te_nxt    = sum_e_r;
          out_pk_nxt    = peak_r;
          out_pr_nxt    = idx_valid_r;
        end
      end
      default: ;
    endcase

    // bucket read out by the previous roll step: take it off the totals, floor at zero
    if (sub_v_r) begin
      sum_b_nxt = (sum_b_r > TOTB_W'(rd_data_r.bytes)) ?
                  sum_b_r - TOTB_W'(rd_data_r.bytes) : '0;
      sum_e_nxt = (sum_e_r > TOTE_W'(rd_data_r.events)) ?
                  sum_e_r - TOTE_W'(rd_data_r.events) : '0;
    end
    if (cmp_v_r && (rd_data_r.bytes > peak_r)) begin
      peak_nxt = rd_data_r.bytes;
    end

    if (cfg_wr) begin
      if (cfg_paddr[2] == REG_SHIFT) begin
        shift_nxt = cfg_pwdata[SHIFT_W-1:0];
      end else begin
        act_nxt = cfg_pwdata[RING_W-1:0];
      end
      sum_b_nxt     = '0;
      sum_e_nxt     = '0;
      newest_nxt    = '0;
      slot_nxt      = '0;
      idx_valid_nxt = 1'b0;
      clr_pend_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r       <= ACTIVE_RESET;
      shift_r     <= SHIFT_RESET;
      wipe_r      <= 1'b0;
      roll_r      <= 1'b0;
      sub_v_r     <= 1'b0;
      cmp_v_r     <= 1'b0;
      clr_pend_r  <= 1'b1;
      sum_b_r     <= '0;
      sum_e_r     <= '0;
      newest_r    <= '0;
      slot_r      <= '0;
      idx_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      act_r       <= act_nxt;
      shift_r     <= shift_nxt;
      wipe_r      <= wipe_nxt;
      roll_r      <= roll_nxt;
      sub_v_r     <= sub_v_nxt;
      cmp_v_r     <= cmp_v_nxt;
      clr_pend_r  <= clr_pend_nxt;
      sum_b_r     <= sum_b_nxt;
      sum_e_r     <= sum_e_nxt;
      newest_r    <= newest_nxt;
      slot_r      <= slot_nxt;
      idx_valid_r <= idx_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    time_r   <= time_nxt;
    byte_r   <= byte_nxt;
    evt_r    <= evt_nxt;
    target_r <= target_nxt;
    steps_r  <= steps_nxt;
    ctr_r    <= ctr_nxt;
    peak_r   <= peak_nxt;
    out_tb_r <= out_tb_nxt;
    out_te_r <= out_te_nxt;
    out_pk_r <= out_pk_nxt;
    out_pr_r <= out_pr_nxt;
  end

  a_wipe_roll_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(wipe_r && roll_r))
    else $error("clear pass and roll both selected");

  a_slot_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= ring_m1)
    else $error("newest slot outside ring");

  a_primed_after_time: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_DIFF) && ((cmd_r == CMD_ADD) || (cmd_r == CMD_ADV)) |=> idx_valid_r)
    else $error("add or advance left meter unprimed");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_DIFF) && (cmd_r == CMD_CLR) |=>
      (sum_b_r == '0) && (sum_e_r == '0) && !idx_valid_r)
    else $error("clear left totals or index");

endmodule

/* tb/sv/sliding_window_rate_meter_tb.sv */
// Self-checking testbench for the sliding-window rate meter: directed table plus random beats.
module sliding_window_rate_meter_tb import swrm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;   // unused code, must report current totals

  localparam logic [63:0] BKTB_MAX = (64'd1 << BKTB_W) - 64'd1;
  localparam logic [63:0] BKTE_MAX = (64'd1 << BKTE_W) - 64'd1;
  localparam logic [63:0] TOTB_MAX = (64'd1 << TOTB_W) - 64'd1;
  localparam logic [63:0] TOTE_MAX = (64'd1 << TOTE_W) - 64'd1;

  localparam int unsigned LONG_GAP    = 300;
  localparam int unsigned ITEM_BUDGET = 700;
  localparam int unsigned CMD_CYCLES  = 2 * MAX_BUCKETS + 12;
  localparam int unsigned RUN_LIMIT   = ITEM_BUDGET * (CMD_CYCLES + 2 * LONG_GAP) * 3;
  localparam logic [TIME_W-1:0] TICKS_PER_BKT = 48'd1024;   // bucket length at reset shift

  typedef struct packed {
    logic [TOTB_W-1:0] tot_bytes;
    logic [TOTE_W-1:0] tot_events;
    logic [BKTB_W-1:0] peak;
    logic              primed;
  } totals_t;

  typedef struct {
    logic [CMD_W-1:0]  op;
    logic [TIME_W-1:0] t;
    logic [BYTE_W-1:0] nbytes;
    logic [EVT_W-1:0]  nevents;
    bit                typed;
    totals_t           want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  swrm_in_if  cmd_if ();
  swrm_out_if res_if ();

  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  sliding_window_rate_meter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (cmd_if),
    .out_ch      (res_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // window state as the block should hold it
  logic [RING_W-1:0]  cfg_active;
  logic [SHIFT_W-1:0] cfg_shift;
  logic [BKTB_W-1:0]  bkt_bytes  [MAX_BUCKETS];
  logic [BKTE_W-1:0]  bkt_events [MAX_BUCKETS];
  logic [TOTB_W-1:0]  win_bytes;
  logic [TOTE_W-1:0]  win_events;
  logic [TIME_W-1:0]  head_index;
  int unsigned        head_slot;
  logic               head_valid;

  totals_t     expected_totals [$];
  totals_t     oldest_totals;
  dir_row_t    dir_tab [$];
  logic [TIME_W-1:0] clock_now;
  int unsigned calm_left;
  int unsigned mismatch_count;
  int unsigned results_checked;
  int unsigned cmds_sent;
  int unsigned settings_used;
  int unsigned cycle_count;

  function automatic int unsigned ring_size();
    int unsigned n;
    n = cfg_active;
    if (n < 2) n = 2;
    if (n > MAX_BUCKETS) n = MAX_BUCKETS;
    return n;
  endfunction

  function automatic logic [63:0] sat_sum(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] lim);
    logic [63:0] s;
    s = a + b;
    return (s > lim) ? lim : s;
  endfunction

  function automatic void zero_buckets();
    foreach (bkt_bytes[i]) begin
      bkt_bytes[i]  = '0;
      bkt_events[i] = '0;
    end
    win_bytes  = '0;
    win_events = '0;
  endfunction

  function automatic void wipe_all();
    zero_buckets();
    head_index = '0;
    head_slot  = 0;
    head_valid = 1'b0;
  endfunction

  function automatic void advance_head(input logic [TIME_W-1:0] target);
    int unsigned n;
    int unsigned slot;
    logic [TIME_W-1:0] steps;
    n = ring_size();
    if (!head_valid) begin
      head_valid = 1'b1;
      head_index = target;
      head_slot  = target % n;
      return;
    end
    if (target <= head_index) return;
    steps = target - head_index;
    if (steps >= n) begin
      zero_buckets();
    end else begin
      slot = head_slot % n;
      for (int unsigned k = 0; k < steps; k++) begin
        slot = (slot + 1 == n) ? 0 : slot + 1;
        win_bytes  = (win_bytes > TOTB_W'(bkt_bytes[slot])) ?
                     win_bytes - TOTB_W'(bkt_bytes[slot]) : '0;
        win_events = (win_events > TOTE_W'(bkt_events[slot])) ?
                     win_events - TOTE_W'(bkt_events[slot]) : '0;
        bkt_bytes[slot]  = '0;
        bkt_events[slot] = '0;
      end
    end
    head_index = target;
    head_slot  = target % n;
  endfunction

  function automatic totals_t predict_step(input logic [CMD_W-1:0] op,
                                           input logic [TIME_W-1:0] t,
                                           input logic [BYTE_W-1:0] nb,
                                           input logic [EVT_W-1:0] ne);
    totals_t r;
    logic [TIME_W-1:0] target;
    int unsigned n;
    int unsigned slot;
    logic [BKTB_W-1:0] pk;
    target = t >> cfg_shift;
    case (op)
      CMD_ADD: begin
        advance_head(target);
        slot = head_slot % ring_size();
        bkt_bytes[slot]  = BKTB_W'(sat_sum(64'(bkt_bytes[slot]), 64'(nb), BKTB_MAX));
        bkt_events[slot] = BKTE_W'(sat_sum(64'(bkt_events[slot]), 64'(ne), BKTE_MAX));
        win_bytes  = TOTB_W'(sat_sum(64'(win_bytes), 64'(nb), TOTB_MAX));
        win_events = TOTE_W'(sat_sum(64'(win_events), 64'(ne), TOTE_MAX));
      end
      CMD_ADV: advance_head(target);
      CMD_CLR: wipe_all();
      default: ;
    endcase
    n  = ring_size();
    pk = '0;
    for (int unsigned i = 0; i < n; i++) begin
      if (bkt_bytes[i] > pk) pk = bkt_bytes[i];
    end
    r.tot_bytes  = win_bytes;
    r.tot_events = win_events;
    r.peak       = pk;
    r.primed     = head_valid;
    return r;
  endfunction

  function automatic totals_t res(input logic [TOTB_W-1:0] tb, input logic [TOTE_W-1:0] te,
                                  input logic [BKTB_W-1:0] pk, input logic pr);
    totals_t r;
    r.tot_bytes  = tb;
    r.tot_events = te;
    r.peak       = pk;
    r.primed     = pr;
    return r;
  endfunction

  function automatic dir_row_t mk_row(input logic [CMD_W-1:0] op, input logic [TIME_W-1:0] t,
                                      input logic [BYTE_W-1:0] nb, input logic [EVT_W-1:0] ne,
                                      input bit typed, input totals_t want);
    dir_row_t r;
    r.op      = op;
    r.t       = t;
    r.nbytes  = nb;
    r.nevents = ne;
    r.typed   = typed;
    r.want    = want;
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] rand48();
    return TIME_W'({$urandom, $urandom});
  endfunction

  // mostly back-to-back or short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(40, LONG_GAP);
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= 100)
      $display("MISMATCH %s: got 0x%0h want 0x%0h (result %0d)", what, got, want,
               results_checked);
  endtask

  // leaves valid high on return; whoever waits next must lower it
  task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [TIME_W-1:0] t,
                          input logic [BYTE_W-1:0] nb, input logic [EVT_W-1:0] ne,
                          input bit typed, input totals_t want);
    int unsigned gap;
    totals_t calc;
    gap = (calm_left > 0) ? 0 : pick_gap();
    if (calm_left > 0) calm_left--;
    else if ($urandom_range(29) == 0) calm_left = $urandom_range(10, 40);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.cmd         <= op;
    cmd_if.time_ticks  <= t;
    cmd_if.byte_count  <= nb;
    cmd_if.event_count <= ne;
    do @(posedge clk); while (!cmd_if.ready);
    calc = predict_step(op, t, nb, ne);
    expected_totals.push_back(typed ? want : calc);
    cmds_sent++;
    @(negedge clk);
  endtask

  task automatic drain(input int unsigned settle);
    cmd_if.valid <= 1'b0;
    while (expected_totals.size() != 0) @(posedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic cfg_write(input logic reg_sel, input logic [CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_sel, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (reg_sel == REG_ACTIVE) cfg_active = value[RING_W-1:0];
    else cfg_shift = value[SHIFT_W-1:0];
    wipe_all();
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic cfg_check(input logic reg_sel, input logic [CFG_DW-1:0] want);
    logic [CFG_DW-1:0] got;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {reg_sel, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    if (got !== want)
      flag_mismatch(reg_sel == REG_ACTIVE ? "active_buckets readback" : "bucket_shift readback",
                    64'(got), 64'(want));
  endtask

  task automatic new_setting(input logic [CFG_DW-1:0] active_raw,
                             input logic [CFG_DW-1:0] shift_raw);
    drain(8);
    cfg_write(REG_ACTIVE, active_raw);
    cfg_write(REG_SHIFT, shift_raw);
    cfg_check(REG_ACTIVE, CFG_DW'(cfg_active));
    cfg_check(REG_SHIFT, CFG_DW'(cfg_shift));
    settings_used++;
    clock_now = rand48();
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned n;
    int unsigned pick;
    logic [TIME_W-1:0] blen;
    logic [TIME_W-1:0] t;
    logic [CMD_W-1:0]  op;
    logic [BYTE_W-1:0] nb;
    logic [EVT_W-1:0]  ne;
    n    = ring_size();
    blen = TIME_W'(1) << cfg_shift;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 60) op = CMD_ADD;
      else if (pick < 85) op = CMD_ADV;
      else if (pick < 93) op = CMD_CLR;
      else op = CMD_NONE;
      pick = $urandom_range(99);
      if (pick < 40) t = clock_now + (rand48() & (blen - 1));
      else if (pick < 75) t = clock_now + TIME_W'($urandom_range(1, n - 1)) * blen;
      else if (pick < 84) t = clock_now + TIME_W'($urandom_range(n, 3 * n)) * blen;
      else if (pick < 93) t = clock_now - TIME_W'($urandom_range(1, n)) * blen;
      else t = rand48();
      if (pick < 84 || pick >= 93) clock_now = t;   // late beats leave the clock alone
      pick = $urandom_range(99);
      if (pick < 12) nb = '1;
      else if (pick < 22) nb = '0;
      else if (pick < 40) nb = BYTE_W'($urandom_range(255));
      else nb = $urandom;
      pick = $urandom_range(99);
      if (pick < 12) ne = '1;
      else if (pick < 22) ne = '0;
      else if (pick < 40) ne = EVT_W'($urandom_range(15));
      else ne = EVT_W'($urandom);
      send_cmd(op, t, nb, ne, 1'b0, '0);
    end
  endtask

  // pile full-size samples into one bucket until it sticks, then roll it out
  task automatic run_saturate(input int unsigned count);
    logic [TIME_W-1:0] blen;
    int unsigned j;
    blen = TIME_W'(1) << cfg_shift;
    for (int unsigned i = 0; i < count; i++) begin
      if (i + 6 >= count) begin
        j = i + 6 - count;
        case (j)
          0: send_cmd(CMD_ADV, blen, $urandom, EVT_W'($urandom), 1'b0, '0);
          1: send_cmd(CMD_ADD, blen + (rand48() & (blen - 1)), $urandom, EVT_W'($urandom),
                      1'b0, '0);
          2: send_cmd(CMD_ADV, TIME_W'(2) * blen, $urandom, EVT_W'($urandom), 1'b0, '0);
          3: send_cmd(CMD_ADD, TIME_W'(2) * blen, $urandom, EVT_W'($urandom), 1'b0, '0);
          4: send_cmd(CMD_ADV, TIME_W'(3) * blen, $urandom, EVT_W'($urandom), 1'b0, '0);
          default: send_cmd(CMD_NONE, rand48(), $urandom, EVT_W'($urandom), 1'b0, '0);
        endcase
      end else if (i % 23 == 22) begin
        send_cmd(($urandom_range(1) == 0) ? CMD_ADV : CMD_NONE, rand48() & (blen - 1),
                 $urandom, EVT_W'($urandom), 1'b0, '0);
      end else begin
        send_cmd(CMD_ADD, rand48() & (blen - 1), '1, EVT_W'($urandom), 1'b0, '0);
      end
    end
  endtask

  // result side: runs of ready, broken by stalls
  initial begin
    res_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 80 : 6)) @(negedge clk);
      j_stall: begin
        int unsigned stall;
        stall = pick_gap();
        if (stall > 0) begin
          res_if.ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_totals.size() == 0) begin
        flag_mismatch("result beat with nothing expected", 64'(res_if.total_bytes), 64'd0);
      end else begin
        oldest_totals = expected_totals.pop_front();
        if (res_if.total_bytes !== oldest_totals.tot_bytes)
          flag_mismatch("total_bytes", 64'(res_if.total_bytes), 64'(oldest_totals.tot_bytes));
        if (res_if.total_events !== oldest_totals.tot_events)
          flag_mismatch("total_events", 64'(res_if.total_events),
                        64'(oldest_totals.tot_events));
        if (res_if.peak_bucket_bytes !== oldest_totals.peak)
          flag_mismatch("peak_bucket_bytes", 64'(res_if.peak_bucket_bytes),
                        64'(oldest_totals.peak));
        if (res_if.primed !== oldest_totals.primed)
          flag_mismatch("primed", 64'(res_if.primed), 64'(oldest_totals.primed));
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > RUN_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still due", cycle_count,
               expected_totals.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    cmd_if.valid       = 1'b0;
    cmd_if.cmd         = CMD_NONE;
    cmd_if.time_ticks  = '0;
    cmd_if.byte_count  = '0;
    cmd_if.event_count = '0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    cycle_count        = 0;
    mismatch_count     = 0;
    results_checked    = 0;
    cmds_sent          = 0;
    settings_used      = 1;
    calm_left          = 0;
    clock_now          = '0;
    cfg_active         = ACTIVE_RESET;
    cfg_shift          = SHIFT_RESET;
    wipe_all();

    // reset settings: 20 buckets of 1024 ticks
    dir_tab.push_back(mk_row(CMD_NONE, '0, '0, '0, 1'b1, res('0, '0, '0, 1'b0)));
    dir_tab.push_back(mk_row(CMD_CLR, '0, '1, '1, 1'b1, res('0, '0, '0, 1'b0)));
    dir_tab.push_back(mk_row(CMD_ADV, '0, '0, '0, 1'b1, res('0, '0, '0, 1'b1)));
    dir_tab.push_back(mk_row(CMD_ADD, 48'h3FF, '1, '1, 1'b1,
                             res(48'hFFFF_FFFF, 40'hFFFF, 40'hFFFF_FFFF, 1'b1)));
    dir_tab.push_back(mk_row(CMD_ADD, TICKS_PER_BKT, 32'd1, 16'd1, 1'b0, '0));
    dir_tab.push_back(mk_row(CMD_ADD, '0, 32'd5, 16'd2, 1'b0, '0));   // late beat
    dir_tab.push_back(mk_row(CMD_ADV, 48'd5 * TICKS_PER_BKT, '0, '0, 1'b0, '0));
    dir_tab.push_back(mk_row(CMD_ADD, 48'd19 * TICKS_PER_BKT + 48'h3FF, 32'h8000_0000,
                             16'h8000, 1'b0, '0));
    dir_tab.push_back(mk_row(CMD_ADV, 48'd21 * TICKS_PER_BKT, '0, '0, 1'b0, '0));
    // step of exactly one ring length empties the window
    dir_tab.push_back(mk_row(CMD_ADV, 48'd41 * TICKS_PER_BKT, '0, '0, 1'b1,
                             res('0, '0, '0, 1'b1)));
    dir_tab.push_back(mk_row(CMD_ADD, '1, '1, '1, 1'b1,
                             res(48'hFFFF_FFFF, 40'hFFFF, 40'hFFFF_FFFF, 1'b1)));
    dir_tab.push_back(mk_row(CMD_NONE, '0, '1, '1, 1'b1,
                             res(48'hFFFF_FFFF, 40'hFFFF, 40'hFFFF_FFFF, 1'b1)));
    dir_tab.push_back(mk_row(CMD_ADD, '0, '0, '0, 1'b0, '0));
    dir_tab.push_back(mk_row(CMD_CLR, '1, '1, '1, 1'b1, res('0, '0, '0, 1'b0)));
    dir_tab.push_back(mk_row(CMD_ADD, '1, 32'h1234_5678, 16'h8000, 1'b1,
                             res(48'h1234_5678, 40'h8000, 40'h1234_5678, 1'b1)));
    dir_tab.push_back(mk_row(CMD_ADV, '1, '0, '0, 1'b0, '0));
    dir_tab.push_back(mk_row(CMD_ADD, 48'h5555_5555_5555, 32'hAAAA_AAAA, 16'h5555, 1'b0, '0));
    dir_tab.push_back(mk_row(CMD_NONE, 48'hAAAA_AAAA_AAAA, 32'h5555_5555, 16'hAAAA, 1'b0,
                             '0));
    dir_tab.push_back(mk_row(CMD_CLR, '0, '0, '0, 1'b1, res('0, '0, '0, 1'b0)));
    dir_tab.push_back(mk_row(CMD_ADD, '0, 32'd100, 16'd1, 1'b0, '0));
    dir_tab.push_back(mk_row(CMD_ADD, TICKS_PER_BKT + 48'h155, 32'd200, 16'd2, 1'b0, '0));
    dir_tab.push_back(mk_row(CMD_ADD, 48'd2 * TICKS_PER_BKT, 32'd300, 16'd3, 1'b0, '0));
    dir_tab.push_back(mk_row(CMD_ADD, 48'd3 * TICKS_PER_BKT, 32'd400, 16'd4, 1'b0, '0));
    // one bucket short of a full ring: only the newest survives
    dir_tab.push_back(mk_row(CMD_ADV, 48'd22 * TICKS_PER_BKT, '0, '0, 1'b0, '0));
    dir_tab.push_back(mk_row(CMD_ADD, 48'd22 * TICKS_PER_BKT, 32'd7, 16'd7, 1'b0, '0));

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    cfg_check(REG_ACTIVE, CFG_DW'(ACTIVE_RESET));
    cfg_check(REG_SHIFT, CFG_DW'(SHIFT_RESET));

    foreach (dir_tab[i])
      send_cmd(dir_tab[i].op, dir_tab[i].t, dir_tab[i].nbytes, dir_tab[i].nevents,
               dir_tab[i].typed, dir_tab[i].want);
    run_random(60);

    new_setting(32'd1, 32'd0);                   // clamps to 2 buckets, 1 tick each
    run_random(60);
    new_setting(32'd0, 32'd31);                  // 2 huge buckets, bucket saturation
    run_saturate(285);
    new_setting(32'd1023, 32'd5);                // clamps to the full ring
    run_random(40);
    new_setting(32'd7, 32'd3);
    run_random(60);
    new_setting(32'hFFFF_FC05, 32'hFFFF_FFE2);   // upper bits dropped by the registers
    run_random(50);

    drain(CMD_CYCLES);
    $display("Checked %0d results for %0d commands across %0d register settings",
             results_checked, cmds_sent, settings_used);
    $display("Ring lengths 2 to 512, shifts 0 to 31, rolls, wraps, late beats, bucket clamp");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* sim.f */
design/swrm_pkg.sv
design/swrm_if.sv
design/swrm_seq.sv
design/sliding_window_rate_meter.sv
tb/sv/sliding_window_rate_meter_tb.sv
